[sv/elsd_pkg.sv]
package elsd_pkg;

    // Newton refinement steps on the nearest-point angle.
    localparam int NEWTON_ITERATIONS = 8;
    localparam int IT_W              = $clog2(NEWTON_ITERATIONS) + 1;

    localparam int CORDIC_STEPS = 31;
    localparam int ANG_W        = 39;
    localparam int TRIG_W       = 36;
    localparam int OP_W         = 34;
    localparam int PROD_W       = 2 * OP_W;

    localparam logic signed [ANG_W-1:0]  ANG_HALF_PI     = 39'sd1686629713;
    localparam logic signed [ANG_W-1:0]  ANG_PI          = 39'sd3373259426;
    localparam logic signed [ANG_W-1:0]  ANG_TWO_PI      = 39'sd6746518852;
    localparam logic signed [ANG_W-1:0]  THETA_LIMIT     = 39'sd68719476736;
    localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 36'sd652032874;
    localparam logic [34:0]              STEP_LIMIT      = 35'd17179869184;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_PRE   = 16'h0002,
        S_DEC   = 16'h0004,
        S_ANORM = 16'h0008,
        S_ATAN  = 16'h0010,
        S_NPRE  = 16'h0020,
        S_RNORM = 16'h0040,
        S_RED   = 16'h0080,
        S_ROT   = 16'h0100,
        S_NMUL  = 16'h0200,
        S_NCHK  = 16'h0400,
        S_DIV   = 16'h0800,
        S_NUPD  = 16'h1000,
        S_FMUL  = 16'h2000,
        S_SQRT  = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    typedef enum logic [1:0] {
        SQ_NORM,
        SQ_CIRC,
        SQ_GEN
    } t_sq_mode;

    // Arctangent of 2^-idx in Q2.30.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Clamp an angle to the first quadrant.
    function automatic logic signed [ANG_W-1:0] clamp_quadrant(
        input logic signed [ANG_W-1:0] th
    );
        logic signed [ANG_W-1:0] v;
        if (th < 0) begin
            v = '0;
        end else if (th > ANG_HALF_PI) begin
            v = ANG_HALF_PI;
        end else begin
            v = th;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[sv/ellipse_signed_distance.sv]
// Signed distance from a Q16.16 point to an axis-aligned ellipse with
// semi-axes a and b. A word is taken when start is high and busy is low;
// busy then stays high until the result appears on o_signed_distance with
// o_valid high for exactly one cycle, and the receiver must take it in that
// cycle because it cannot stall the block. A shape with exactly one zero
// axis, or a point at the centre of a non-circle, needs no iteration; two zero
// axes or a circle pass through the 32-step square root. The general
// ellipse runs up to eight Newton steps, each through the CORDIC rotator,
// the angle reduction, the shared 34 by 34 bit multiplier and, unless the
// step saturates, the restoring divider, after the start-up normalisation
// shifts and the arctangent CORDIC; a last rotation and multiply sequence
// and the 32-step square root then give the result. The result is
// negative inside, positive on or outside the ellipse, and saturated to
// the 32-bit range. A new word may be started in the same cycle as a
// result is shown.
module ellipse_signed_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_point_u,
    input  logic signed [31:0] i_point_v,
    input  logic        [30:0] i_semi_axis_a,
    input  logic        [30:0] i_semi_axis_b,
    output logic               o_valid,
    output logic signed [31:0] o_signed_distance
);
    import elsd_pkg::*;

    t_state                   r_state;
    logic [3:0]               r_seq;
    logic [5:0]               r_i;
    logic [IT_W-1:0]          r_it;
    logic [31:0]              r_au, r_av;
    logic [30:0]              r_a, r_b;
    logic [63:0]              r_acc, r_X, r_Y;
    logic signed [63:0]       r_cx, r_cy;
    logic signed [32:0]       r_z;
    logic signed [ANG_W-1:0]  r_theta, r_r;
    logic                     r_neg;
    logic signed [TRIG_W-1:0] r_x, r_y;
    logic signed [OP_W-1:0]   r_st, r_ct, r_sc, r_c2;
    logic [63:0]              r_pn, r_qn, r_rn;
    logic                     r_rneg;
    logic signed [63:0]       r_f, r_fp;
    logic [63:0]              r_rem, r_df;
    logic [34:0]              r_quo;
    logic                     r_dneg;
    logic                     r_ret_final;
    logic [33:0]              r_mx, r_my;
    logic [61:0]              r_ab;
    logic [127:0]             r_big1, r_big2;
    logic [63:0]              r_sq_n, r_sq_res;
    t_sq_mode                 r_sq_mode;
    logic signed [33:0]       r_res;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_valid;
    logic signed [31:0]       r_dist;

    // Shared multiplier operands.
    logic signed [OP_W-1:0]   mul_a, mul_b;

    logic [31:0]              in_u_abs, in_v_abs;
    logic                     dec_swap;
    logic signed [63:0]       an_max;
    logic signed [63:0]       at_cx_sh, at_cy_sh, at_cx_n, at_cy_n;
    logic signed [32:0]       at_tab, at_z_n;
    logic signed [TRIG_W-1:0] rt_x_sh, rt_y_sh, rt_x_n, rt_y_n;
    logic signed [ANG_W-1:0]  rt_tab, rt_r_n;
    logic signed [ANG_W-1:0]  rd_r1, rd_r2;
    logic                     rd_neg;
    logic [63:0]              rn_max;
    logic signed [OP_W-1:0]   pn_op, qn_op, rn_op;
    logic signed [PROD_W-1:0] c2_diff;
    logic [63:0]              nc_nf, nc_df;
    logic                     nc_ovf;
    logic [1:0]               dv_sh;
    logic [66:0]              dv_dsh;
    logic                     dv_ge_int, dv_ge_frac;
    logic [64:0]              dv_r2;
    logic [63:0]              dv_rem_n;
    logic                     dv_bit;
    logic signed [35:0]       nu_step;
    logic signed [ANG_W-1:0]  nu_th_raw, nu_th;
    logic                     nu_exit;
    logic signed [37:0]       fm_ex, fm_dx, fm_mag;
    logic [31:0]              fm_base;
    logic [63:0]              sq_bit, sq_trial, sq_res_n;
    logic                     sq_ge;
    logic signed [33:0]       sq_root, sq_out;
    logic [63:0]              prod_lo;

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_signed_distance = r_dist;

    assign in_u_abs = i_point_u[31] ? (~i_point_u + 32'd1) : i_point_u;
    assign in_v_abs = i_point_v[31] ? (~i_point_v + 32'd1) : i_point_v;
    assign dec_swap = (r_X < r_Y);
    assign prod_lo  = r_prod[63:0];

    // Normalisation of the arctangent operands.
    assign an_max = (r_cx > r_cy) ? r_cx : r_cy;

    // One arctangent (vectoring) CORDIC step.
    assign at_cx_sh = r_cx >>> r_i[4:0];
    assign at_cy_sh = r_cy >>> r_i[4:0];
    assign at_tab   = $signed({1'b0, atan_entry(r_i[4:0])});
    assign at_cx_n  = (r_cy > 0) ? (r_cx + at_cy_sh) : (r_cx - at_cy_sh);
    assign at_cy_n  = (r_cy > 0) ? (r_cy - at_cx_sh) : (r_cy + at_cx_sh);
    assign at_z_n   = (r_cy > 0) ? (r_z + at_tab) : (r_z - at_tab);

    // One sine/cosine (rotation) CORDIC step.
    assign rt_x_sh = r_x >>> r_i[4:0];
    assign rt_y_sh = r_y >>> r_i[4:0];
    assign rt_tab  = ANG_W'($signed({1'b0, atan_entry(r_i[4:0])}));
    assign rt_x_n  = (r_r >= 0) ? (r_x - rt_y_sh) : (r_x + rt_y_sh);
    assign rt_y_n  = (r_r >= 0) ? (r_y + rt_x_sh) : (r_y - rt_x_sh);
    assign rt_r_n  = (r_r >= 0) ? (r_r - rt_tab) : (r_r + rt_tab);

    // Fold a reduced angle in [0, 2pi) into [-pi/2, pi/2].
    always_comb begin
        rd_r1  = (r_r > ANG_PI) ? (r_r - ANG_TWO_PI) : r_r;
        rd_neg = 1'b0;
        rd_r2  = rd_r1;
        if (rd_r1 > ANG_HALF_PI) begin
            rd_r2  = rd_r1 - ANG_PI;
            rd_neg = 1'b1;
        end else if (rd_r1 < -ANG_HALF_PI) begin
            rd_r2  = rd_r1 + ANG_PI;
            rd_neg = 1'b1;
        end
    end

    // Newton coefficients share one normalising shift.
    always_comb begin
        rn_max = (r_pn > r_qn) ? r_pn : r_qn;
        if (r_rn > rn_max) begin
            rn_max = r_rn;
        end
    end

    assign pn_op   = $signed({4'b0, r_pn[29:0]});
    assign qn_op   = $signed({4'b0, r_qn[29:0]});
    assign rn_op   = r_rneg ? -$signed({4'b0, r_rn[29:0]}) : $signed({4'b0, r_rn[29:0]});
    assign c2_diff = $signed({4'b0, r_acc}) - r_prod;

    // Divider set-up: magnitudes and the step saturation test.
    assign nc_nf  = r_f[63] ? 64'(-r_f) : r_f;
    assign nc_df  = r_fp[63] ? 64'(-r_fp) : r_fp;
    assign nc_ovf = ({4'b0, nc_nf} >= {nc_df, 4'b0});

    // Restoring division: four integer quotient bits, then thirty fraction bits.
    assign dv_sh      = 2'(6'd3 - r_i);
    assign dv_dsh     = {3'b0, r_df} << dv_sh;
    assign dv_ge_int  = ({3'b0, r_rem} >= dv_dsh);
    assign dv_r2      = {r_rem, 1'b0};
    assign dv_ge_frac = (dv_r2 >= {1'b0, r_df});
    always_comb begin
        if (r_i < 6'd4) begin
            dv_bit   = dv_ge_int;
            dv_rem_n = dv_ge_int ? (r_rem - dv_dsh[63:0]) : r_rem;
        end else begin
            dv_bit   = dv_ge_frac;
            dv_rem_n = dv_ge_frac ? 64'(dv_r2 - {1'b0, r_df}) : dv_r2[63:0];
        end
    end

    // Angle update after a Newton step.
    assign nu_step = r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign nu_th_raw = r_theta - ANG_W'(nu_step);
    always_comb begin
        if (nu_th_raw > THETA_LIMIT) begin
            nu_th = THETA_LIMIT;
        end else if (nu_th_raw < -THETA_LIMIT) begin
            nu_th = -THETA_LIMIT;
        end else begin
            nu_th = nu_th_raw;
        end
    end
    assign nu_exit = (r_quo == '0) || (r_it == IT_W'(NEWTON_ITERATIONS - 1));

    // Offset from the nearest ellipse point along one axis.
    assign fm_base = (r_seq == 4'd1) ? r_au : r_av;
    assign fm_ex   = r_prod[PROD_W-1:30];
    assign fm_dx   = $signed({6'b0, fm_base}) - fm_ex;
    assign fm_mag  = fm_dx[37] ? -fm_dx : fm_dx;

    // One digit of the integer square root.
    assign sq_bit   = 64'h4000_0000_0000_0000 >> {r_i[4:0], 1'b0};
    assign sq_trial = r_sq_res + sq_bit;
    assign sq_ge    = (r_sq_n >= sq_trial);
    assign sq_res_n = sq_ge ? ((r_sq_res >> 1) + sq_bit) : (r_sq_res >> 1);
    assign sq_root  = $signed({2'b0, sq_res_n[31:0]});
    always_comb begin
        case (r_sq_mode)
            SQ_CIRC: sq_out = sq_root - $signed({3'b0, r_a});
            SQ_GEN:  sq_out = (r_big1 < r_big2) ? -sq_root : sq_root;
            default: sq_out = sq_root;
        endcase
    end

    // Operand selection for the shared multiplier. Each multiply sequence issues
    // one product per cycle, bar an idle slot in S_FMUL, and uses each in the next.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PRE: begin
                case (r_seq)
                    4'd0: begin
                        mul_a = $signed({2'b0, r_au});
                        mul_b = $signed({2'b0, r_au});
                    end
                    4'd1: begin
                        mul_a = $signed({2'b0, r_av});
                        mul_b = $signed({2'b0, r_av});
                    end
                    4'd2: begin
                        mul_a = $signed({2'b0, r_au});
                        mul_b = $signed({3'b0, r_b});
                    end
                    4'd3: begin
                        mul_a = $signed({2'b0, r_av});
                        mul_b = $signed({3'b0, r_a});
                    end
                    default: ;
                endcase
            end
            S_NPRE: begin
                case (r_seq)
                    4'd0: begin
                        mul_a = $signed({3'b0, r_a});
                        mul_b = $signed({2'b0, r_au});
                    end
                    4'd1: begin
                        mul_a = $signed({3'b0, r_b});
                        mul_b = $signed({2'b0, r_av});
                    end
                    4'd2: begin
                        mul_a = $signed({3'b0, r_a});
                        mul_b = $signed({3'b0, r_a});
                    end
                    4'd3: begin
                        mul_a = $signed({3'b0, r_b});
                        mul_b = $signed({3'b0, r_b});
                    end
                    default: ;
                endcase
            end
            S_NMUL: begin
                case (r_seq)
                    4'd0: begin
                        mul_a = r_st;
                        mul_b = r_ct;
                    end
                    4'd1: begin
                        mul_a = r_ct;
                        mul_b = r_ct;
                    end
                    4'd2: begin
                        mul_a = r_st;
                        mul_b = r_st;
                    end
                    4'd3: begin
                        mul_a = pn_op;
                        mul_b = r_st;
                    end
                    4'd4: begin
                        mul_a = qn_op;
                        mul_b = r_ct;
                    end
                    4'd5: begin
                        mul_a = rn_op;
                        mul_b = r_sc;
                    end
                    4'd6: begin
                        mul_a = pn_op;
                        mul_b = r_ct;
                    end
                    4'd7: begin
                        mul_a = qn_op;
                        mul_b = r_st;
                    end
                    4'd8: begin
                        mul_a = rn_op;
                        mul_b = r_c2;
                    end
                    default: ;
                endcase
            end
            S_FMUL: begin
                case (r_seq)
                    4'd0: begin
                        mul_a = $signed({3'b0, r_a});
                        mul_b = r_ct;
                    end
                    4'd1: begin
                        mul_a = $signed({3'b0, r_b});
                        mul_b = r_st;
                    end
                    4'd2: begin
                        mul_a = $signed(r_mx);
                        mul_b = $signed(r_mx);
                    end
                    4'd3: begin
                        mul_a = $signed(r_my);
                        mul_b = $signed(r_my);
                    end
                    4'd4: begin
                        mul_a = $signed({2'b0, r_X[31:0]});
                        mul_b = $signed({2'b0, r_X[31:0]});
                    end
                    4'd5: begin
                        mul_a = $signed({2'b0, r_X[31:0]});
                        mul_b = $signed({2'b0, r_X[63:32]});
                    end
                    4'd6: begin
                        mul_a = $signed({2'b0, r_X[63:32]});
                        mul_b = $signed({2'b0, r_X[63:32]});
                    end
                    4'd7: begin
                        mul_a = $signed({2'b0, r_Y[31:0]});
                        mul_b = $signed({2'b0, r_Y[31:0]});
                    end
                    4'd8: begin
                        mul_a = $signed({2'b0, r_Y[31:0]});
                        mul_b = $signed({2'b0, r_Y[63:32]});
                    end
                    4'd9: begin
                        mul_a = $signed({2'b0, r_Y[63:32]});
                        mul_b = $signed({2'b0, r_Y[63:32]});
                    end
                    4'd10: begin
                        mul_a = $signed({3'b0, r_a});
                        mul_b = $signed({3'b0, r_b});
                    end
                    4'd12: begin
                        mul_a = $signed({2'b0, r_ab[31:0]});
                        mul_b = $signed({2'b0, r_ab[31:0]});
                    end
                    4'd13: begin
                        mul_a = $signed({2'b0, r_ab[31:0]});
                        mul_b = $signed({4'b0, r_ab[61:32]});
                    end
                    4'd14: begin
                        mul_a = $signed({4'b0, r_ab[61:32]});
                        mul_b = $signed({4'b0, r_ab[61:32]});
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_au    <= in_u_abs;
                        r_av    <= in_v_abs;
                        r_a     <= i_semi_axis_a;
                        r_b     <= i_semi_axis_b;
                        r_seq   <= '0;
                        r_state <= S_PRE;
                    end
                end

                S_PRE: begin
                    r_seq <= r_seq + 4'd1;
                    case (r_seq)
                        4'd1: r_acc <= prod_lo;
                        4'd2: r_acc <= r_acc + prod_lo;
                        4'd3: r_X <= prod_lo;
                        4'd4: begin
                            r_Y     <= prod_lo;
                            r_state <= S_DEC;
                        end
                        default: ;
                    endcase
                end

                S_DEC: begin
                    r_sq_n   <= r_acc;
                    r_sq_res <= '0;
                    r_i      <= '0;
                    if (r_a == '0 && r_b == '0) begin
                        r_sq_mode <= SQ_NORM;
                        r_state   <= S_SQRT;
                    end else if (r_a == '0) begin
                        r_res   <= $signed({2'b0, r_av}) - $signed({3'b0, r_b});
                        r_state <= S_DONE;
                    end else if (r_b == '0) begin
                        r_res   <= $signed({2'b0, r_au}) - $signed({3'b0, r_a});
                        r_state <= S_DONE;
                    end else if (r_a == r_b) begin
                        r_sq_mode <= SQ_CIRC;
                        r_state   <= S_SQRT;
                    end else if ((r_X | r_Y) == '0) begin
                        // The point sits at the centre of the ellipse.
                        r_res <= (r_a < r_b) ? -$signed({3'b0, r_a})
                                             : -$signed({3'b0, r_b});
                        r_state <= S_DONE;
                    end else begin
                        if (dec_swap) begin
                            r_au <= r_av;
                            r_av <= r_au;
                            r_a  <= r_b;
                            r_b  <= r_a;
                            r_X  <= r_Y;
                            r_Y  <= r_X;
                            r_cx <= $signed(r_Y);
                            r_cy <= $signed(r_X);
                        end else begin
                            r_cx <= $signed(r_X);
                            r_cy <= $signed(r_Y);
                        end
                        r_state <= S_ANORM;
                    end
                end

                S_ANORM: begin
                    if (an_max >= 64'sh0800_0000_0000_0000) begin
                        r_cx <= r_cx >>> 1;
                        r_cy <= r_cy >>> 1;
                    end else if (an_max < 64'sh0400_0000_0000_0000) begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end else begin
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= S_ATAN;
                    end
                end

                S_ATAN: begin
                    r_cx <= at_cx_n;
                    r_cy <= at_cy_n;
                    r_z  <= at_z_n;
                    r_i  <= r_i + 6'd1;
                    if (r_i == 6'(CORDIC_STEPS - 1)) begin
                        r_theta <= ANG_W'(at_z_n);
                        r_seq   <= '0;
                        r_state <= S_NPRE;
                    end
                end

                S_NPRE: begin
                    r_seq <= r_seq + 4'd1;
                    case (r_seq)
                        4'd1: r_pn <= prod_lo;
                        4'd2: r_qn <= prod_lo;
                        4'd3: r_acc <= prod_lo;
                        4'd4: begin
                            r_rneg  <= (r_a < r_b);
                            r_rn    <= (r_a < r_b) ? (prod_lo - r_acc) : (r_acc - prod_lo);
                            r_state <= S_RNORM;
                        end
                        default: ;
                    endcase
                end

                S_RNORM: begin
                    if (rn_max >= 64'h4000_0000) begin
                        r_pn <= r_pn >> 1;
                        r_qn <= r_qn >> 1;
                        r_rn <= r_rn >> 1;
                    end else if (rn_max < 64'h2000_0000) begin
                        r_pn <= r_pn << 1;
                        r_qn <= r_qn << 1;
                        r_rn <= r_rn << 1;
                    end else begin
                        r_it        <= '0;
                        r_r         <= r_theta;
                        r_ret_final <= 1'b0;
                        r_state     <= S_RED;
                    end
                end

                S_RED: begin
                    if (r_r < 0) begin
                        r_r <= r_r + ANG_TWO_PI;
                    end else if (r_r >= ANG_TWO_PI) begin
                        r_r <= r_r - ANG_TWO_PI;
                    end else begin
                        r_r     <= rd_r2;
                        r_neg   <= rd_neg;
                        r_x     <= CORDIC_INV_GAIN;
                        r_y     <= '0;
                        r_i     <= '0;
                        r_state <= S_ROT;
                    end
                end

                S_ROT: begin
                    r_x <= rt_x_n;
                    r_y <= rt_y_n;
                    r_r <= rt_r_n;
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'(CORDIC_STEPS - 1)) begin
                        r_ct    <= OP_W'(r_neg ? -rt_x_n : rt_x_n);
                        r_st    <= OP_W'(r_neg ? -rt_y_n : rt_y_n);
                        r_seq   <= '0;
                        r_state <= r_ret_final ? S_FMUL : S_NMUL;
                    end
                end

                S_NMUL: begin
                    r_seq <= r_seq + 4'd1;
                    case (r_seq)
                        4'd1: r_sc <= r_prod[63:30];
                        4'd2: r_acc <= prod_lo;
                        4'd3: r_c2 <= c2_diff[63:30];
                        4'd4: r_f <= r_prod[63:0];
                        4'd5: r_f <= r_f - r_prod[63:0];
                        4'd6: r_f <= r_f + r_prod[63:0];
                        4'd7: r_fp <= r_prod[63:0];
                        4'd8: r_fp <= r_fp + r_prod[63:0];
                        4'd9: begin
                            r_fp    <= r_fp + r_prod[63:0];
                            r_state <= S_NCHK;
                        end
                        default: ;
                    endcase
                end

                S_NCHK: begin
                    if (r_fp == '0) begin
                        // Flat derivative: stop refining.
                        r_r         <= clamp_quadrant(r_theta);
                        r_ret_final <= 1'b1;
                        r_state     <= S_RED;
                    end else begin
                        r_dneg <= r_f[63] ^ r_fp[63];
                        r_rem  <= nc_nf;
                        r_df   <= nc_df;
                        r_i    <= '0;
                        if (nc_ovf) begin
                            r_quo   <= STEP_LIMIT;
                            r_state <= S_NUPD;
                        end else begin
                            r_quo   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end

                S_DIV: begin
                    r_rem <= dv_rem_n;
                    r_quo <= {r_quo[33:0], dv_bit};
                    r_i   <= r_i + 6'd1;
                    if (r_i == 6'd33) begin
                        r_state <= S_NUPD;
                    end
                end

                S_NUPD: begin
                    r_theta <= nu_th;
                    if (nu_exit) begin
                        r_r         <= clamp_quadrant(nu_th);
                        r_ret_final <= 1'b1;
                    end else begin
                        r_r         <= nu_th;
                        r_ret_final <= 1'b0;
                        r_it        <= r_it + IT_W'(1);
                    end
                    r_state <= S_RED;
                end

                S_FMUL: begin
                    r_seq <= r_seq + 4'd1;
                    case (r_seq)
                        4'd1:  r_mx <= fm_mag[33:0];
                        4'd2:  r_my <= fm_mag[33:0];
                        4'd3:  r_acc <= prod_lo;
                        4'd4:  r_acc <= r_acc + prod_lo;
                        4'd5:  r_big1 <= {64'b0, prod_lo};
                        4'd6:  r_big1 <= r_big1 + ({64'b0, prod_lo} << 33);
                        4'd7:  r_big1 <= r_big1 + ({64'b0, prod_lo} << 64);
                        4'd8:  r_big1 <= r_big1 + {64'b0, prod_lo};
                        4'd9:  r_big1 <= r_big1 + ({64'b0, prod_lo} << 33);
                        4'd10: r_big1 <= r_big1 + ({64'b0, prod_lo} << 64);
                        4'd11: r_ab <= prod_lo[61:0];
                        4'd13: r_big2 <= {64'b0, prod_lo};
                        4'd14: r_big2 <= r_big2 + ({64'b0, prod_lo} << 33);
                        4'd15: begin
                            r_big2    <= r_big2 + ({64'b0, prod_lo} << 64);
                            r_sq_n    <= r_acc;
                            r_sq_res  <= '0;
                            r_i       <= '0;
                            r_sq_mode <= SQ_GEN;
                            r_state   <= S_SQRT;
                        end
                        default: ;
                    endcase
                end

                S_SQRT: begin
                    if (sq_ge) begin
                        r_sq_n <= r_sq_n - sq_trial;
                    end
                    r_sq_res <= sq_res_n;
                    r_i      <= r_i + 6'd1;
                    if (r_i == 6'd31) begin
                        r_res   <= sq_out;
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    r_dist  <= sat32(r_res);
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/elsd_checker.sv]
module elsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_valid
);

    // An accepted word always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("block not busy after accepting a word");

    // A result is shown only once the block has finished.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("result shown while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid)
        else $error("result strobe longer than one cycle");

    // Finishing a word always delivers its result.
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_busy) |-> i_valid)
        else $error("word finished without a result");

endmodule

bind ellipse_signed_distance elsd_checker u_elsd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid)
);
